>>> hdl/mfcg_pkg.sv
// ----------------------------------------------------------------------------
// mfcg_pkg - shared types and constants of the Manchester frame chip generator
// Beat layouts, command format, state codes and frame constants.
// ----------------------------------------------------------------------------
package mfcg_pkg;

  // Frame constants
  localparam int SYNC_BITS      = 32;  // 8..32
  localparam int TRAILER_PULSES = 8;   // 0..8
  localparam int PREAMBLE_MAX   = 64;
  localparam int CHIPS_PER_BEAT = 16;

  localparam int SYNC_C0   = (SYNC_BITS > CHIPS_PER_BEAT) ? CHIPS_PER_BEAT : SYNC_BITS;
  localparam int SYNC_C1   = SYNC_BITS - SYNC_C0;
  localparam int SYNC_SH0  = SYNC_BITS - SYNC_C0;
  localparam int SYNC_PAD0 = CHIPS_PER_BEAT - SYNC_C0;
  localparam int SYNC_PAD1 = CHIPS_PER_BEAT - SYNC_C1;
  localparam bit SYNC_TWO  = (SYNC_C1 > 0);
  localparam int TRAILER_K = (2 * TRAILER_PULSES > CHIPS_PER_BEAT) ?
                             CHIPS_PER_BEAT : 2 * TRAILER_PULSES;

  // Register reset values
  localparam logic [31:0] SYNC_WORD_RST = 32'h930B_51DE;
  localparam logic [6:0]  PREAMBLE_RST  = 7'd16;
  localparam logic [7:0]  MAX_LEN_RST   = 8'd32;

  // Queue sizes
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_SYNC_WORD = 2'd0,
    CFG_PREAMBLE  = 2'd1,
    CFG_MAX_LEN   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_BYTE  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    SEC_PREAMBLE = 3'd0,
    SEC_SYNC     = 3'd1,
    SEC_PAYLOAD  = 3'd2,
    SEC_TRAILER  = 3'd3,
    SEC_STATUS   = 3'd4
  } section_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREAMBLE,
    BK_SYNC_HI,
    BK_SYNC_LO,
    BK_TRAILER
  } bk_state_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  frame_length;
    logic [7:0]  data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] chips;
    logic [4:0]  chip_count;
    logic [2:0]  section;
    logic [1:0]  status;
    logic        frame_end;
  } out_beat_t;

  // Front to back command
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;   // reject reason
    logic        last;     // trailer follows
    logic [7:0]  data;
  } cmd_t;

endpackage

>>> hdl/mfcg_front.sv
// ----------------------------------------------------------------------------
// mfcg_front - input classifier
// Tracks the open frame and turns each input beat into one command.
// ----------------------------------------------------------------------------
module mfcg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  mfcg_pkg::in_beat_t in_data,
  input  logic [7:0]       max_length,
  input  logic             q_full,
  output logic             cmd_push,
  output mfcg_pkg::cmd_t   cmd
);

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       accept;

  assign full     = q_full;
  assign accept   = push & ~q_full;
  assign cmd_push = accept;

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    cmd.kind       = mfcg_pkg::CMD_REJECT;
    cmd.status     = mfcg_pkg::ST_OK;
    cmd.last       = 1'b0;
    cmd.data       = in_data.data_byte;
    if (in_data.func == mfcg_pkg::FUNC_START) begin
      frame_open_nxt = 1'b0;
      bytes_left_nxt = 8'd0;
      if (in_data.frame_length > max_length) begin
        cmd.status = mfcg_pkg::ST_TOO_LONG;
      end else begin
        cmd.kind = mfcg_pkg::CMD_START;
        cmd.last = (in_data.frame_length == 8'd0);
        if (in_data.frame_length != 8'd0) begin
          frame_open_nxt = 1'b1;
          bytes_left_nxt = in_data.frame_length;
        end
      end
    end else if (!frame_open_r || bytes_left_r == 8'd0) begin
      frame_open_nxt = 1'b0;
      cmd.status     = mfcg_pkg::ST_NO_FRAME;
    end else begin
      cmd.kind       = mfcg_pkg::CMD_BYTE;
      cmd.last       = (bytes_left_r == 8'd1);
      bytes_left_nxt = bytes_left_r - 8'd1;
      frame_open_nxt = (bytes_left_r != 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 8'd0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

>>> hdl/mfcg_cmd_queue.sv
// ----------------------------------------------------------------------------
// mfcg_cmd_queue - command queue
// Short first-in first-out store between classifier and sequencer.
// ----------------------------------------------------------------------------
module mfcg_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  mfcg_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output mfcg_pkg::cmd_t rd_cmd,
  output logic           empty
);

  mfcg_pkg::cmd_t                entry_r [mfcg_pkg::CMDQ_DEPTH];
  logic [mfcg_pkg::CMDQ_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [mfcg_pkg::CMDQ_CW-1:0]  cnt_r;
  logic                          do_wr, do_rd;

  assign full   = (cnt_r == mfcg_pkg::CMDQ_CW'(mfcg_pkg::CMDQ_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en & ~full;
  assign do_rd  = rd_en & ~empty;
  assign rd_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/mfcg_back.sv
// ----------------------------------------------------------------------------
// mfcg_back - chip sequencer
// Expands commands into chip beats, one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module mfcg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  input  mfcg_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  input  logic [31:0]           sync_word,
  input  logic [6:0]            preamble_pulses,
  output logic                  empty,
  input  logic                  pop,
  output mfcg_pkg::out_beat_t   out_data
);

  function automatic logic [15:0] top_mask(input logic [4:0] k);
    return ~(16'hFFFF >> k);
  endfunction

  function automatic logic [15:0] manchester(input logic [7:0] d);
    logic [15:0] c;
    c = '0;
    for (int j = 0; j < 8; j++) begin
      c[2*j +: 2] = d[j] ? 2'b10 : 2'b01;
    end
    return c;
  endfunction

  mfcg_pkg::bk_state_t state_r, state_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic                last_r, last_nxt;

  mfcg_pkg::out_beat_t          q_r [mfcg_pkg::OUTQ_DEPTH];
  logic [mfcg_pkg::OUTQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mfcg_pkg::OUTQ_CW-1:0] cnt_r;

  logic                emit, take, room;
  mfcg_pkg::out_beat_t res;
  logic [6:0]          pre_sat;
  logic [4:0]          k_pre;
  logic [15:0]         chunk0, chunk1;

  assign empty    = (cnt_r == '0);
  assign take     = pop & ~empty;
  assign room     = (cnt_r != mfcg_pkg::OUTQ_CW'(mfcg_pkg::OUTQ_DEPTH)) | take;
  assign out_data = q_r[rd_ptr_r];

  assign pre_sat = (preamble_pulses > 7'(mfcg_pkg::PREAMBLE_MAX)) ?
                   7'(mfcg_pkg::PREAMBLE_MAX) : preamble_pulses;
  assign k_pre   = (rem_r > 8'(mfcg_pkg::CHIPS_PER_BEAT)) ?
                   5'(mfcg_pkg::CHIPS_PER_BEAT) : rem_r[4:0];
  assign chunk0  = 16'(sync_word >> mfcg_pkg::SYNC_SH0) << mfcg_pkg::SYNC_PAD0;
  assign chunk1  = 16'(sync_word) << mfcg_pkg::SYNC_PAD1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfcg_pkg::BK_IDLE;
      rem_r   <= 8'd0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    last_nxt  = last_r;
    emit      = 1'b0;
    cmd_pop   = 1'b0;
    res       = '0;
    case (state_r)
      mfcg_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.kind)
            mfcg_pkg::CMD_START: begin
              cmd_pop   = 1'b1;
              last_nxt  = cmd.last;
              rem_nxt   = {pre_sat, 1'b0};
              state_nxt = (pre_sat == 7'd0) ? mfcg_pkg::BK_SYNC_HI : mfcg_pkg::BK_PREAMBLE;
            end
            mfcg_pkg::CMD_BYTE: begin
              if (room) begin
                cmd_pop        = 1'b1;
                emit           = 1'b1;
                res.chips      = manchester(cmd.data);
                res.chip_count = 5'(mfcg_pkg::CHIPS_PER_BEAT);
                res.section    = mfcg_pkg::SEC_PAYLOAD;
                if (cmd.last) begin
                  state_nxt = mfcg_pkg::BK_TRAILER;
                end
              end
            end
            default: begin
              if (room) begin
                cmd_pop       = 1'b1;
                emit          = 1'b1;
                res.section   = mfcg_pkg::SEC_STATUS;
                res.status    = cmd.status;
                res.frame_end = 1'b1;
              end
            end
          endcase
        end
      end
      mfcg_pkg::BK_PREAMBLE: begin
        if (room) begin
          emit           = 1'b1;
          res.chips      = 16'hAAAA & top_mask(k_pre);
          res.chip_count = k_pre;
          res.section    = mfcg_pkg::SEC_PREAMBLE;
          rem_nxt        = rem_r - 8'(k_pre);
          if (rem_r == 8'(k_pre)) begin
            state_nxt = mfcg_pkg::BK_SYNC_HI;
          end
        end
      end
      mfcg_pkg::BK_SYNC_HI: begin
        if (room) begin
          emit           = 1'b1;
          res.chips      = chunk0;
          res.chip_count = 5'(mfcg_pkg::SYNC_C0);
          res.section    = mfcg_pkg::SEC_SYNC;
          if (mfcg_pkg::SYNC_TWO) begin
            state_nxt = mfcg_pkg::BK_SYNC_LO;
          end else begin
            state_nxt = last_r ? mfcg_pkg::BK_TRAILER : mfcg_pkg::BK_IDLE;
          end
        end
      end
      mfcg_pkg::BK_SYNC_LO: begin
        if (room) begin
          emit           = 1'b1;
          res.chips      = chunk1;
          res.chip_count = 5'(mfcg_pkg::SYNC_C1);
          res.section    = mfcg_pkg::SEC_SYNC;
          state_nxt      = last_r ? mfcg_pkg::BK_TRAILER : mfcg_pkg::BK_IDLE;
        end
      end
      mfcg_pkg::BK_TRAILER: begin
        if (room) begin
          emit           = 1'b1;
          res.chips      = 16'hAAAA & top_mask(5'(mfcg_pkg::TRAILER_K));
          res.chip_count = 5'(mfcg_pkg::TRAILER_K);
          res.section    = mfcg_pkg::SEC_TRAILER;
          res.frame_end  = 1'b1;
          state_nxt      = mfcg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mfcg_pkg::BK_IDLE;
      end
    endcase
  end

  // result queue
  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (emit) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (emit && !take) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (take && !emit) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/manchester_frame_chip_generator_unit.sv
// ----------------------------------------------------------------------------
// manchester_frame_chip_generator_unit - radio frame chip stream generator
// Preamble, sync word, Manchester payload and trailer, up to 16 chips per beat.
// ----------------------------------------------------------------------------
//
//  channel  handshake           payload           notes
//  input    push / full         in_data           start beat or payload byte
//  result   empty / pop         out_data          up to 16 chips per beat
//  config   cfg_we              cfg_index/data    0 sync, 1 preamble, 2 max len
//
//  The sequencer emits one result beat per cycle until a stalled pop lets the
//  two-deep result queue fill. A payload byte gives one beat, the last also
//  the trailer; a start beat is loaded, then gives up to 8 preamble beats,
//  a sync beat per 16 sync chips and, for an empty frame, the trailer. Reset
//  (rst_n low, synchronous) empties both queues, closes any open frame and
//  loads the register defaults. full follows the two-deep command queue.
//
module manchester_frame_chip_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  mfcg_pkg::in_beat_t  in_data,
  // result channel
  output logic                empty,
  input  logic                pop,
  output mfcg_pkg::out_beat_t out_data,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Config registers
  logic [31:0] sync_word_r;
  logic [6:0]  preamble_r;
  logic [7:0]  max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= mfcg_pkg::SYNC_WORD_RST;
      preamble_r  <= mfcg_pkg::PREAMBLE_RST;
      max_len_r   <= mfcg_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfcg_pkg::CFG_SYNC_WORD: sync_word_r <= cfg_data;
        mfcg_pkg::CFG_PREAMBLE:  preamble_r  <= cfg_data[6:0];
        mfcg_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_data[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front: classify input beats into commands
  logic           q_full, q_empty, cmd_push, cmd_pop;
  mfcg_pkg::cmd_t cmd_in, cmd_out;

  mfcg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .max_length (max_len_r),
    .q_full     (q_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // Decoupling queue
  mfcg_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd_in),
    .full   (q_full),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_out),
    .empty  (q_empty)
  );

  // Back: expand commands into chip beats
  mfcg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (q_empty),
    .cmd             (cmd_out),
    .cmd_pop         (cmd_pop),
    .sync_word       (sync_word_r),
    .preamble_pulses (preamble_r),
    .empty           (empty),
    .pop             (pop),
    .out_data        (out_data)
  );

endmodule

>>> tb/tb_manchester_frame_chip_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_manchester_frame_chip_generator_unit - self-checking bench for the chip
// generator
// A tracker class predicts every result beat from each accepted input beat
// and matches the results in order, field by field. A directed part covers
// the field extremes and corner frames. Random frames follow under several
// register settings, with random stalls on both queues and one long hold-off
// at the result side.
// ----------------------------------------------------------------------------
import mfcg_pkg::*;

class frame_chip_tracker;
  logic [31:0] sync_word;
  logic [6:0]  preamble_pulses;
  logic [7:0]  max_len;
  bit          frame_open;
  logic [7:0]  bytes_left;
  out_beat_t   beats_due[$];
  int          mismatches;

  function new();
    sync_word       = SYNC_WORD_RST;
    preamble_pulses = PREAMBLE_RST;
    max_len         = MAX_LEN_RST;
    frame_open      = 1'b0;
    bytes_left      = 8'd0;
    mismatches      = 0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [31:0] value);
    case (idx)
      CFG_SYNC_WORD: sync_word = value;
      CFG_PREAMBLE:  preamble_pulses = value[6:0];
      CFG_MAX_LEN:   max_len = value[7:0];
      default: ;
    endcase
  endfunction

  // k chips from bit 15 down
  function logic [15:0] top_mask(int k);
    logic [15:0] m;
    m = 16'hFFFF;
    return m << (16 - k);
  endfunction

  function void add_beat(logic [15:0] chips, int count, section_t sec, status_t st, bit last);
    out_beat_t b;
    b.chips      = chips;
    b.chip_count = count[4:0];
    b.section    = sec;
    b.status     = st;
    b.frame_end  = last;
    beats_due.push_back(b);
  endfunction

  function void add_trailer();
    int k;
    k = (2 * TRAILER_PULSES > 16) ? 16 : 2 * TRAILER_PULSES;
    add_beat(16'hAAAA & top_mask(k), k, SEC_TRAILER, ST_OK, 1'b1);
  endfunction

  // Works out every result beat that one accepted input beat gives
  function void take_item(in_beat_t b);
    int          rem;
    int          nbits;
    int          k;
    logic [63:0] sw;
    logic [63:0] part;
    logic [15:0] chips;
    if (b.func == FUNC_START) begin
      // a start always drops any open frame, trailer or not
      frame_open = 1'b0;
      bytes_left = 8'd0;
      if (b.frame_length > max_len) begin
        add_beat(16'h0000, 0, SEC_STATUS, ST_TOO_LONG, 1'b1);
        return;
      end
      rem = (preamble_pulses > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_pulses;
      rem = rem * 2;
      while (rem > 0) begin
        k = (rem > 16) ? 16 : rem;
        add_beat(16'hAAAA & top_mask(k), k, SEC_PREAMBLE, ST_OK, 1'b0);
        rem -= k;
      end
      nbits = (SYNC_BITS > 32) ? 32 : SYNC_BITS;
      sw = {32'h0, sync_word} & ((64'd1 << nbits) - 64'd1);
      while (nbits > 0) begin
        k = (nbits > 16) ? 16 : nbits;
        part = (sw >> (nbits - k)) & ((64'd1 << k) - 64'd1);
        part = part << (16 - k);
        add_beat(part[15:0], k, SEC_SYNC, ST_OK, 1'b0);
        nbits -= k;
      end
      if (b.frame_length == 8'd0) begin
        add_trailer();
      end else begin
        frame_open = 1'b1;
        bytes_left = b.frame_length;
      end
      return;
    end
    if (!frame_open || bytes_left == 8'd0) begin
      frame_open = 1'b0;
      add_beat(16'h0000, 0, SEC_STATUS, ST_NO_FRAME, 1'b1);
      return;
    end
    chips = 16'h0000;
    for (int j = 7; j >= 0; j--) begin
      chips = {chips[13:0], b.data_byte[j] ? 2'b10 : 2'b01};
    end
    add_beat(chips, 16, SEC_PAYLOAD, ST_OK, 1'b0);
    bytes_left = bytes_left - 8'd1;
    if (bytes_left == 8'd0) begin
      frame_open = 1'b0;
      add_trailer();
    end
  endfunction

  task flag_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  task match_beat(out_beat_t got);
    out_beat_t want;
    if (beats_due.size() == 0) begin
      flag_mismatch($sformatf("result beat %h with none expected", got));
      return;
    end
    want = beats_due.pop_front();
    if (got.chips !== want.chips)
      flag_mismatch($sformatf("chips %h, want %h", got.chips, want.chips));
    if (got.chip_count !== want.chip_count)
      flag_mismatch($sformatf("chip_count %0d, want %0d", got.chip_count, want.chip_count));
    if (got.section !== want.section)
      flag_mismatch($sformatf("section %0d, want %0d", got.section, want.section));
    if (got.status !== want.status)
      flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.frame_end !== want.frame_end)
      flag_mismatch($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
  endtask
endclass

module tb_manchester_frame_chip_generator_unit;

  localparam int SETTLE_CYCLES = 20;        // sequencer plus both queues, with margin
  localparam int HOLD_CYCLES   = 120;       // long result hold-off, fills both queues
  localparam int TIMEOUT_NS    = 4_000_000; // many times the slowest legal run

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_beat_t    in_data;
  logic        empty;
  logic        pop;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  frame_chip_tracker tracker;

  // shared between sender and receiver
  bit calm;       // no idling on either side
  bit hold_req;   // ask the receiver for its one long hold-off
  bit hold_done;  // receiver side: hold-off already served

  manchester_frame_chip_generator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Both handshakes sampled at the rising edge; input first, so a beat is
  // predicted before any result could ever refer to it
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full)
        tracker.take_item(in_data);
      if (pop && !empty)
        tracker.match_beat(out_data);
    end
  end

  // Result side: random stalls, calm stretch, one long hold-off
  initial begin
    pop       = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        pop = 1'b0;
        // counted here while the sender keeps offering beats
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      pop = rst_n && (calm || ($urandom_range(99) >= 14));
    end
  end

  function automatic in_beat_t start_beat(logic [7:0] len);
    in_beat_t b;
    b.func         = FUNC_START;
    b.frame_length = len;
    b.data_byte    = $urandom_range(255); // ignored on a start
    return b;
  endfunction

  function automatic in_beat_t byte_beat(logic [7:0] d);
    in_beat_t b;
    b.func         = FUNC_BYTE;
    b.frame_length = $urandom_range(255); // ignored on a byte
    b.data_byte    = d;
    return b;
  endfunction

  // Called and returns at a falling edge; push stays high between back to
  // back beats
  task automatic send_item(in_beat_t b);
    if (!calm && $urandom_range(99) < 14) begin
      push = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    push    = 1'b1;
    in_data = b;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Registers only change while nothing is in flight
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic settle();
    push = 1'b0;
    while (tracker.beats_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly whole frames with random bytes; the rest is rejects, stray bytes
  // and frames cut short by a fresh start
  task automatic run_random(int quota);
    int sent;
    int len;
    int nb;
    int pick;
    int top;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        top = (tracker.max_len < 6) ? tracker.max_len : 6;
        len = $urandom_range(top);
        if ($urandom_range(9) == 0)
          len = $urandom_range(tracker.max_len);
        nb = (len > 6) ? $urandom_range(3) : len;
        if (nb > 0 && $urandom_range(9) == 0)
          nb = $urandom_range(nb - 1); // abandoned frame
        send_item(start_beat(len));
        repeat (nb) send_item(byte_beat($urandom_range(255)));
        sent += 1 + nb;
      end else if (pick < 82 && tracker.max_len != 8'd255) begin
        send_item(start_beat($urandom_range(255, tracker.max_len + 1)));
        sent++;
      end else if (pick < 94) begin
        send_item(byte_beat($urandom_range(255)));
        sent++;
      end else begin
        send_item(start_beat($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    tracker   = new();
    rst_n     = 1'b0;
    push      = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SYNC_WORD;
    cfg_data  = 32'h0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed, reset settings ---
    send_item(byte_beat(8'hFF));    // byte before any frame
    send_item(start_beat(8'd0));    // empty frame: straight to trailer
    send_item(start_beat(8'd3));
    send_item(byte_beat(8'h00));
    send_item(byte_beat(8'hFF));
    send_item(byte_beat(8'hA5));    // last byte brings the trailer
    send_item(start_beat(8'd33));   // one above max length
    send_item(start_beat(8'd32));   // exactly max length
    send_item(byte_beat(8'h5A));
    send_item(start_beat(8'd1));    // start inside an open frame
    send_item(byte_beat(8'h3C));
    send_item(byte_beat(8'h01));    // frame already closed
    settle();

    // --- low extremes: no preamble, zero sync, nothing allowed ---
    write_reg(CFG_SYNC_WORD, 32'h0000_0000);
    write_reg(CFG_PREAMBLE, 32'd0);
    write_reg(CFG_MAX_LEN, 32'd0);
    send_item(start_beat(8'd0));
    send_item(start_beat(8'd1));
    send_item(start_beat(8'd255));
    send_item(byte_beat(8'h80));
    settle();

    // --- high extremes: preamble saturates at 64 pulses ---
    write_reg(CFG_SYNC_WORD, 32'hFFFF_FFFF);
    write_reg(CFG_PREAMBLE, 32'd127);
    write_reg(CFG_MAX_LEN, 32'd255);
    send_item(start_beat(8'd255));
    send_item(byte_beat(8'hFF));
    send_item(start_beat(8'd2));
    send_item(byte_beat(8'h55));
    send_item(byte_beat(8'hAA));
    settle();
    write_reg(CFG_PREAMBLE, 32'd65);
    send_item(start_beat(8'd0));

    // --- random phases ---
    for (int p = 0; p < 4; p++) begin
      settle();
      write_reg(CFG_SYNC_WORD, $urandom());
      case (p)
        0: begin
          write_reg(CFG_PREAMBLE, $urandom_range(20));
          write_reg(CFG_MAX_LEN, $urandom_range(255, 8));
          hold_req = 1'b1;
        end
        1: begin
          write_reg(CFG_PREAMBLE, $urandom_range(127));
          write_reg(CFG_MAX_LEN, $urandom_range(255));
        end
        2: begin
          calm = 1'b1;
          write_reg(CFG_PREAMBLE, 32'd64);
          write_reg(CFG_MAX_LEN, 32'd255);
        end
        default: begin
          calm = 1'b0;
          write_reg(CFG_PREAMBLE, 32'd1);
          write_reg(CFG_MAX_LEN, $urandom_range(10));
        end
      endcase
      run_random(27);
    end

    settle();
    if (tracker.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
